// ----- rtl/esc_pkg.sv -----
// shared types, constants and arithmetic helpers for the sensor compensation pipeline
package esc_pkg;

    // pipeline depths
    localparam int TEMP_LAT   = 5;
    localparam int DIV_BITS   = 32;
    localparam int PRESS_LAT  = 7 + DIV_BITS + 5;
    localparam int HUM_STAGES = 11;
    localparam int HUM_DELAY  = PRESS_LAT - HUM_STAGES;
    localparam int TOTAL_LAT  = TEMP_LAT + PRESS_LAT;

    // configuration register indexes
    localparam logic [2:0] REG_TEMP    = 3'd0;
    localparam logic [2:0] REG_PRESS_A = 3'd1;
    localparam logic [2:0] REG_PRESS_B = 3'd2;
    localparam logic [2:0] REG_PRESS_C = 3'd3;
    localparam logic [2:0] REG_HUM_A   = 3'd4;
    localparam logic [2:0] REG_HUM_B   = 3'd5;

    // compensation constants
    localparam logic [31:0] P_OFFSET  = 32'd64000;
    localparam logic [31:0] P_FULL    = 32'd1048576;
    localparam logic [31:0] P_SCALE   = 32'd3125;
    localparam logic [31:0] P_UNITY   = 32'd32768;
    localparam logic [31:0] H_OFFSET  = 32'd76800;
    localparam logic [31:0] H_ROUND_A = 32'd16384;
    localparam logic [31:0] H_BIAS    = 32'd2097152;
    localparam logic [31:0] H_ROUND_B = 32'd8192;
    localparam logic [31:0] H_LIMIT   = 32'd419430400;

    // calibration words, each widened to 32 bits
    typedef struct packed {
        logic [31:0] t1;
        logic [31:0] t2;
        logic [31:0] t3;
        logic [31:0] p1;
        logic [31:0] p2;
        logic [31:0] p3;
        logic [31:0] p4;
        logic [31:0] p5;
        logic [31:0] p6;
        logic [31:0] p7;
        logic [31:0] p8;
        logic [31:0] p9;
        logic [31:0] h1;
        logic [31:0] h2;
        logic [31:0] h3;
        logic [31:0] h4;
        logic [31:0] h5;
        logic [31:0] h6;
    } coef_t;

    // temperature results carried alongside humidity
    typedef struct packed {
        logic [31:0] fine;
        logic [31:0] centi;
    } meas_t;

    typedef struct packed {
        logic [31:0] fine;
        logic [31:0] centi;
        logic [16:0] humidity;
    } hum_res_t;

    // flags that ride through the divider
    typedef struct packed {
        logic invalid;
        logic dbl;
    } div_side_t;

    typedef struct packed {
        logic [31:0] rem;
        logic [31:0] num;
    } div_state_t;

    // low 32 bits of a product, same for signed and unsigned
    function automatic logic [31:0] mul32(input logic [31:0] a, input logic [31:0] b);
        logic [63:0] p;
        p = {32'd0, a} * {32'd0, b};
        return p[31:0];
    endfunction

    // arithmetic right shift
    function automatic logic [31:0] asr(input logic [31:0] x, input int unsigned n);
        return 32'($signed(x) >>> n);
    endfunction

    // one restoring division step
    function automatic div_state_t div_step(input div_state_t s, input logic [31:0] den);
        logic [33:0] trial;
        div_state_t  r;
        trial = {1'b0, s.rem, s.num[31]} - {2'b00, den};
        if (!trial[33])
        begin
            r.rem = trial[31:0];
            r.num = {s.num[30:0], 1'b1};
        end
        else
        begin
            r.rem = {s.rem[30:0], s.num[31]};
            r.num = {s.num[30:0], 1'b0};
        end
        return r;
    endfunction

endpackage

// ----- rtl/esc_temp.sv -----
// temperature stages: fine temperature and hundredths of a degree
module esc_temp (
    input  logic               clk,
    input  logic               adv,
    input  logic [19:0]        raw_temperature,
    input  logic [19:0]        raw_pressure,
    input  logic [15:0]        raw_humidity,
    input  esc_pkg::coef_t     coef,
    output logic [31:0]        fine_temperature,
    output logic [31:0]        temperature_centi,
    output logic [19:0]        raw_pressure_out,
    output logic [15:0]        raw_humidity_out
);

    logic [31:0] x1_reg, x1_next, d_reg, d_next;
    logic [31:0] m1_reg, m1_next, dd_reg, dd_next;
    logic [31:0] a_reg, a_next, m2_reg, m2_next;
    logic [31:0] tf_reg, tf_next;
    logic [31:0] tf5_reg, tc_reg, tc_next;
    logic [19:0] rawp_reg [esc_pkg::TEMP_LAT];
    logic [15:0] rawh_reg [esc_pkg::TEMP_LAT];

    // stage arithmetic
    always_comb
    begin
        x1_next = ({12'd0, raw_temperature} >> 3) - (coef.t1 << 1);
        d_next  = ({12'd0, raw_temperature} >> 4) - coef.t1;
        m1_next = esc_pkg::mul32(x1_reg, coef.t2);
        dd_next = esc_pkg::mul32(d_reg, d_reg);
        a_next  = esc_pkg::asr(m1_reg, 11);
        m2_next = esc_pkg::mul32(esc_pkg::asr(dd_reg, 12), coef.t3);
        tf_next = a_reg + esc_pkg::asr(m2_reg, 14);
        tc_next = esc_pkg::asr(esc_pkg::mul32(tf_reg, 32'd5) + 32'd128, 8);
    end

    // stage registers
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            x1_reg  <= x1_next;
            d_reg   <= d_next;
            m1_reg  <= m1_next;
            dd_reg  <= dd_next;
            a_reg   <= a_next;
            m2_reg  <= m2_next;
            tf_reg  <= tf_next;
            tf5_reg <= tf_reg;
            tc_reg  <= tc_next;
            rawp_reg[0] <= raw_pressure;
            rawh_reg[0] <= raw_humidity;
            for (int i = 1; i < esc_pkg::TEMP_LAT; i++)
            begin
                rawp_reg[i] <= rawp_reg[i-1];
                rawh_reg[i] <= rawh_reg[i-1];
            end
        end
    end

    assign fine_temperature  = tf5_reg;
    assign temperature_centi = tc_reg;
    assign raw_pressure_out  = rawp_reg[esc_pkg::TEMP_LAT-1];
    assign raw_humidity_out  = rawh_reg[esc_pkg::TEMP_LAT-1];

endmodule

// ----- rtl/esc_div.sv -----
// pipelined restoring divider, one quotient bit per stage
module esc_div (
    input  logic                 clk,
    input  logic                 adv,
    input  logic [31:0]          num,
    input  logic [31:0]          den,
    input  esc_pkg::div_side_t   side_in,
    output logic [31:0]          quo,
    output esc_pkg::div_side_t   side_out
);

    esc_pkg::div_state_t st_reg   [esc_pkg::DIV_BITS];
    esc_pkg::div_state_t st_next  [esc_pkg::DIV_BITS];
    logic [31:0]         den_reg  [esc_pkg::DIV_BITS];
    esc_pkg::div_side_t  side_reg [esc_pkg::DIV_BITS];
    esc_pkg::div_state_t st_first;

    // one step per stage
    always_comb
    begin
        st_first.rem = 32'd0;
        st_first.num = num;
        st_next[0] = esc_pkg::div_step(st_first, den);
        for (int i = 1; i < esc_pkg::DIV_BITS; i++)
        begin
            st_next[i] = esc_pkg::div_step(st_reg[i-1], den_reg[i-1]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            st_reg[0]   <= st_next[0];
            den_reg[0]  <= den;
            side_reg[0] <= side_in;
            for (int i = 1; i < esc_pkg::DIV_BITS; i++)
            begin
                st_reg[i]   <= st_next[i];
                den_reg[i]  <= den_reg[i-1];
                side_reg[i] <= side_reg[i-1];
            end
        end
    end

    assign quo      = st_reg[esc_pkg::DIV_BITS-1].num;
    assign side_out = side_reg[esc_pkg::DIV_BITS-1];

endmodule

// ----- rtl/esc_press.sv -----
// pressure stages around the divider
module esc_press (
    input  logic            clk,
    input  logic            adv,
    input  logic [31:0]     fine_temperature,
    input  logic [19:0]     raw_pressure,
    input  esc_pkg::coef_t  coef,
    output logic [31:0]     pressure_pa,
    output logic            pressure_invalid
);

    logic [31:0] pa1_reg, pa1_next, pq1_reg, pq1_next;
    logic [31:0] sq2_reg, sq2_next, m5a_reg, m5a_next, m2a_reg, m2a_next;
    logic [31:0] b1_reg, b1_next, m3_reg, m3_next, m5b_reg, m2b_reg;
    logic [31:0] b4_reg, b4_next, a4_reg, a4_next;
    logic [31:0] m6_reg, m6_next, pre_reg, pre_next;
    logic [31:0] den6_reg, den6_next, m7_reg, m7_next;
    logic [31:0] num7_reg, num7_next, den7_reg, den7_next;
    logic [19:0] adc_reg [4];
    esc_pkg::div_side_t side7_reg, side7_next, side_d;
    logic [31:0] quo;
    logic [31:0] q1_reg, q1_next, q2_reg, q3_reg, q4_reg;
    logic [31:0] sqp_reg, sqp_next, mb_reg, mb_next;
    logic [31:0] ma_reg, ma_next, b3_reg, b3_next, s4_reg, s4_next;
    logic [31:0] out_reg, out_next;
    logic        inv_reg [5];

    // stages ahead of the divider
    always_comb
    begin
        pa1_next  = esc_pkg::asr(fine_temperature, 1) - esc_pkg::P_OFFSET;
        pq1_next  = esc_pkg::asr(pa1_next, 2);
        sq2_next  = esc_pkg::mul32(pq1_reg, pq1_reg);
        m5a_next  = esc_pkg::mul32(pa1_reg, coef.p5);
        m2a_next  = esc_pkg::mul32(coef.p2, pa1_reg);
        b1_next   = esc_pkg::mul32(esc_pkg::asr(sq2_reg, 11), coef.p6);
        m3_next   = esc_pkg::mul32(coef.p3, esc_pkg::asr(sq2_reg, 13));
        b4_next   = esc_pkg::asr(b1_reg + (m5b_reg << 1), 2) + (coef.p4 << 16);
        a4_next   = esc_pkg::asr(esc_pkg::asr(m3_reg, 3) + esc_pkg::asr(m2b_reg, 1), 18);
        m6_next   = esc_pkg::mul32(esc_pkg::P_UNITY + a4_reg, coef.p1);
        pre_next  = (esc_pkg::P_FULL - {12'd0, adc_reg[3]}) - esc_pkg::asr(b4_reg, 12);
        den6_next = esc_pkg::asr(m6_reg, 15);
        m7_next   = esc_pkg::mul32(pre_reg, esc_pkg::P_SCALE);
        // a zero divisor marks the item invalid; divide by one to keep the unit quiet
        side7_next.invalid = (den6_reg == 32'd0);
        side7_next.dbl     = m7_reg[31];
        num7_next = m7_reg[31] ? m7_reg : (m7_reg << 1);
        den7_next = side7_next.invalid ? 32'd1 : den6_reg;
    end

    // stages after the divider
    always_comb
    begin
        q1_next  = side_d.dbl ? (quo << 1) : quo;
        sqp_next = esc_pkg::mul32(q1_reg >> 3, q1_reg >> 3);
        mb_next  = esc_pkg::mul32(q1_reg >> 2, coef.p8);
        ma_next  = esc_pkg::mul32(coef.p9, sqp_reg >> 13);
        b3_next  = esc_pkg::asr(mb_reg, 13);
        s4_next  = esc_pkg::asr(ma_reg, 12) + b3_reg + coef.p7;
        out_next = inv_reg[3] ? 32'd0 : (q4_reg + esc_pkg::asr(s4_reg, 4));
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pa1_reg   <= pa1_next;
            pq1_reg   <= pq1_next;
            sq2_reg   <= sq2_next;
            m5a_reg   <= m5a_next;
            m2a_reg   <= m2a_next;
            b1_reg    <= b1_next;
            m3_reg    <= m3_next;
            m5b_reg   <= m5a_reg;
            m2b_reg   <= m2a_reg;
            b4_reg    <= b4_next;
            a4_reg    <= a4_next;
            m6_reg    <= m6_next;
            pre_reg   <= pre_next;
            den6_reg  <= den6_next;
            m7_reg    <= m7_next;
            num7_reg  <= num7_next;
            den7_reg  <= den7_next;
            side7_reg <= side7_next;
            adc_reg[0] <= raw_pressure;
            for (int i = 1; i < 4; i++)
            begin
                adc_reg[i] <= adc_reg[i-1];
            end
            q1_reg  <= q1_next;
            q2_reg  <= q1_reg;
            q3_reg  <= q2_reg;
            q4_reg  <= q3_reg;
            sqp_reg <= sqp_next;
            mb_reg  <= mb_next;
            ma_reg  <= ma_next;
            b3_reg  <= b3_next;
            s4_reg  <= s4_next;
            out_reg <= out_next;
            inv_reg[0] <= side_d.invalid;
            for (int i = 1; i < 5; i++)
            begin
                inv_reg[i] <= inv_reg[i-1];
            end
        end
    end

    esc_div u_div (
        .clk      (clk),
        .adv      (adv),
        .num      (num7_reg),
        .den      (den7_reg),
        .side_in  (side7_reg),
        .quo      (quo),
        .side_out (side_d)
    );

    assign pressure_pa      = out_reg;
    assign pressure_invalid = inv_reg[4];

endmodule

// ----- rtl/esc_hum.sv -----
// humidity stages plus the alignment line for the temperature results
module esc_hum (
    input  logic              clk,
    input  logic              adv,
    input  logic [31:0]       fine_temperature,
    input  logic [31:0]       temperature_centi,
    input  logic [15:0]       raw_humidity,
    input  esc_pkg::coef_t    coef,
    output esc_pkg::hum_res_t res
);

    logic [31:0] hv1_reg, hv1_next;
    logic [15:0] raw1_reg, raw2_reg;
    logic [31:0] mh5_reg, mh5_next, mh6_reg, mh6_next, mh3_reg, mh3_next;
    logic [31:0] ha3_reg, ha3_next, hb3_reg, hb3_next, hd3_reg, hd3_next;
    logic [31:0] ha4_reg, ha5_reg, ha6_reg, ha7_reg;
    logic [31:0] mbd_reg, mbd_next, b5_reg, b5_next, mb6_reg, mb6_next;
    logic [31:0] b7_reg, b7_next, hv8_reg, hv8_next;
    logic [31:0] sq9_reg, sq9_next, hv9_reg, m10_reg, m10_next, hv10_reg;
    logic [31:0] hdiff, hclamp, hshift;
    logic [16:0] hum_reg, hum_next;
    esc_pkg::meas_t    meas_reg [esc_pkg::HUM_STAGES];
    esc_pkg::meas_t    meas_in;
    esc_pkg::hum_res_t dly_in;
    esc_pkg::hum_res_t dly_reg [esc_pkg::HUM_DELAY];

    always_comb
    begin
        hv1_next = fine_temperature - esc_pkg::H_OFFSET;
        mh5_next = esc_pkg::mul32(coef.h5, hv1_reg);
        mh6_next = esc_pkg::mul32(hv1_reg, coef.h6);
        mh3_next = esc_pkg::mul32(hv1_reg, coef.h3);
        ha3_next = esc_pkg::asr(({16'd0, raw2_reg} << 14) - (coef.h4 << 20) - mh5_reg
                                + esc_pkg::H_ROUND_A, 15);
        hb3_next = esc_pkg::asr(mh6_reg, 10);
        hd3_next = esc_pkg::asr(mh3_reg, 11) + esc_pkg::P_UNITY;
        mbd_next = esc_pkg::mul32(hb3_reg, hd3_reg);
        b5_next  = esc_pkg::asr(mbd_reg, 10) + esc_pkg::H_BIAS;
        mb6_next = esc_pkg::mul32(b5_reg, coef.h2);
        b7_next  = esc_pkg::asr(mb6_reg + esc_pkg::H_ROUND_B, 14);
        hv8_next = esc_pkg::mul32(ha7_reg, b7_reg);
        sq9_next = esc_pkg::mul32(esc_pkg::asr(hv8_reg, 15), esc_pkg::asr(hv8_reg, 15));
        m10_next = esc_pkg::mul32(esc_pkg::asr(sq9_reg, 7), coef.h1);
        // clamp to 0..100 %rh before the final shift
        hdiff = hv10_reg - esc_pkg::asr(m10_reg, 4);
        if (hdiff[31])
        begin
            hclamp = 32'd0;
        end
        else if (hdiff > esc_pkg::H_LIMIT)
        begin
            hclamp = esc_pkg::H_LIMIT;
        end
        else
        begin
            hclamp = hdiff;
        end
        hshift   = hclamp >> 12;
        hum_next = hshift[16:0];
        meas_in.fine  = fine_temperature;
        meas_in.centi = temperature_centi;
        dly_in.fine     = meas_reg[esc_pkg::HUM_STAGES-1].fine;
        dly_in.centi    = meas_reg[esc_pkg::HUM_STAGES-1].centi;
        dly_in.humidity = hum_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            hv1_reg  <= hv1_next;
            raw1_reg <= raw_humidity;
            raw2_reg <= raw1_reg;
            mh5_reg  <= mh5_next;
            mh6_reg  <= mh6_next;
            mh3_reg  <= mh3_next;
            ha3_reg  <= ha3_next;
            hb3_reg  <= hb3_next;
            hd3_reg  <= hd3_next;
            ha4_reg  <= ha3_reg;
            ha5_reg  <= ha4_reg;
            ha6_reg  <= ha5_reg;
            ha7_reg  <= ha6_reg;
            mbd_reg  <= mbd_next;
            b5_reg   <= b5_next;
            mb6_reg  <= mb6_next;
            b7_reg   <= b7_next;
            hv8_reg  <= hv8_next;
            sq9_reg  <= sq9_next;
            hv9_reg  <= hv8_reg;
            m10_reg  <= m10_next;
            hv10_reg <= hv9_reg;
            hum_reg  <= hum_next;
            meas_reg[0] <= meas_in;
            for (int i = 1; i < esc_pkg::HUM_STAGES; i++)
            begin
                meas_reg[i] <= meas_reg[i-1];
            end
            dly_reg[0] <= dly_in;
            for (int i = 1; i < esc_pkg::HUM_DELAY; i++)
            begin
                dly_reg[i] <= dly_reg[i-1];
            end
        end
    end

    assign res = dly_reg[esc_pkg::HUM_DELAY-1];

endmodule

// ----- rtl/env_sensor_compensation_top.sv -----
// top level: configuration registers, valid chain and output packing
// pipeline: input accept to result valid passes 5 temperature stages,
// 7 pressure stages, 32 divider stages and 5 pressure finishing stages
// throughput: one item per cycle; the whole pipeline holds while the output stalls
// reset: valid chain and calibration registers clear to zero; datapath is not reset
module env_sensor_compensation_top (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    input  logic [55:0]   s_axis_tdata,   // raw_temperature, raw_pressure, raw_humidity
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    output logic [119:0]  m_axis_tdata,   // fine_temperature, temperature_centi,
                                          // pressure_pa, humidity_q10, zero fill
    output logic          m_axis_tuser,   // pressure_invalid
    input  logic          cfg_valid,
    output logic          cfg_ready,
    input  logic [2:0]    cfg_index,
    input  logic [47:0]   cfg_data
);

    logic [47:0] temp_reg, press_a_reg, press_b_reg, press_c_reg;
    logic [31:0] hum_a_reg, hum_b_reg;
    logic [esc_pkg::TOTAL_LAT-1:0] vld_reg, vld_next;
    logic        adv;
    esc_pkg::coef_t    coef;
    esc_pkg::hum_res_t hres;
    logic [31:0] tf, tc, press;
    logic [19:0] rawp;
    logic [15:0] rawh;
    logic        pinv;

    // calibration register writes
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            temp_reg    <= '0;
            press_a_reg <= '0;
            press_b_reg <= '0;
            press_c_reg <= '0;
            hum_a_reg   <= '0;
            hum_b_reg   <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                esc_pkg::REG_TEMP:    temp_reg    <= cfg_data;
                esc_pkg::REG_PRESS_A: press_a_reg <= cfg_data;
                esc_pkg::REG_PRESS_B: press_b_reg <= cfg_data;
                esc_pkg::REG_PRESS_C: press_c_reg <= cfg_data;
                esc_pkg::REG_HUM_A:   hum_a_reg   <= cfg_data[31:0];
                esc_pkg::REG_HUM_B:   hum_b_reg   <= cfg_data[31:0];
                default: ;
            endcase
        end
    end

    // unpack calibration words
    always_comb
    begin
        coef.t1 = {16'd0, temp_reg[15:0]};
        coef.t2 = {{16{temp_reg[31]}}, temp_reg[31:16]};
        coef.t3 = {{16{temp_reg[47]}}, temp_reg[47:32]};
        coef.p1 = {16'd0, press_a_reg[15:0]};
        coef.p2 = {{16{press_a_reg[31]}}, press_a_reg[31:16]};
        coef.p3 = {{16{press_a_reg[47]}}, press_a_reg[47:32]};
        coef.p4 = {{16{press_b_reg[15]}}, press_b_reg[15:0]};
        coef.p5 = {{16{press_b_reg[31]}}, press_b_reg[31:16]};
        coef.p6 = {{16{press_b_reg[47]}}, press_b_reg[47:32]};
        coef.p7 = {{16{press_c_reg[15]}}, press_c_reg[15:0]};
        coef.p8 = {{16{press_c_reg[31]}}, press_c_reg[31:16]};
        coef.p9 = {{16{press_c_reg[47]}}, press_c_reg[47:32]};
        coef.h1 = {24'd0, hum_a_reg[7:0]};
        coef.h2 = {{16{hum_a_reg[23]}}, hum_a_reg[23:8]};
        coef.h3 = {24'd0, hum_a_reg[31:24]};
        coef.h4 = {{20{hum_b_reg[11]}}, hum_b_reg[11:0]};
        coef.h5 = {{20{hum_b_reg[23]}}, hum_b_reg[23:12]};
        coef.h6 = {{24{hum_b_reg[31]}}, hum_b_reg[31:24]};
    end

    // whole pipeline advances unless the output holds an untaken item
    assign adv           = !vld_reg[esc_pkg::TOTAL_LAT-1] || m_axis_tready;
    assign s_axis_tready = adv;
    assign vld_next      = {vld_reg[esc_pkg::TOTAL_LAT-2:0], s_axis_tvalid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= vld_next;
        end
    end

    esc_temp u_temp (
        .clk               (clk),
        .adv               (adv),
        .raw_temperature   (s_axis_tdata[19:0]),
        .raw_pressure      (s_axis_tdata[39:20]),
        .raw_humidity      (s_axis_tdata[55:40]),
        .coef              (coef),
        .fine_temperature  (tf),
        .temperature_centi (tc),
        .raw_pressure_out  (rawp),
        .raw_humidity_out  (rawh)
    );

    esc_press u_press (
        .clk              (clk),
        .adv              (adv),
        .fine_temperature (tf),
        .raw_pressure     (rawp),
        .coef             (coef),
        .pressure_pa      (press),
        .pressure_invalid (pinv)
    );

    esc_hum u_hum (
        .clk               (clk),
        .adv               (adv),
        .fine_temperature  (tf),
        .temperature_centi (tc),
        .raw_humidity      (rawh),
        .coef              (coef),
        .res               (hres)
    );

    // output packing
    assign m_axis_tvalid = vld_reg[esc_pkg::TOTAL_LAT-1];
    assign m_axis_tdata  = {7'd0, hres.humidity, press, hres.centi, hres.fine};
    assign m_axis_tuser  = pinv;

    // checks
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(vld_reg))
        else $error("pipeline moved during output stall");

    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> vld_reg[0])
        else $error("accepted item not in first stage");

    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[95:64] == 32'd0)
        else $error("invalid pressure not zero");

    a_hum_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[112:96] <= 17'd102400)
        else $error("humidity out of range");

endmodule
